// ===== hdl/bcpc_pkg.sv =====
// Shared types, codes and helpers for the battery charge phase controller.
package bcpc_pkg;

  // Timer width and output widths
  localparam int unsigned TIMER_BITS = 24;
  localparam int unsigned TOTAL_BITS = 24;
  localparam int unsigned SAT_BITS   = (TIMER_BITS > TOTAL_BITS) ? TIMER_BITS : TOTAL_BITS;
  localparam int unsigned CFG_DW     = 13;
  localparam int unsigned CFG_AW     = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Charge phases
  typedef enum logic [2:0] {
    PH_PRE  = 3'd0,
    PH_CC   = 3'd1,
    PH_FULL = 3'd2,
    PH_HOLD = 3'd3,
    PH_ERR  = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_PRE_TO_CC_MV    = 3'd0,
    REG_RECHARGE_MV     = 3'd1,
    REG_AC_INPUT_MA     = 3'd2,
    REG_NONSTD_INPUT_MA = 3'd3,
    REG_USB_INPUT_MA    = 3'd4,
    REG_CV_TARGET_MV    = 3'd5,
    REG_TICK_SECONDS    = 3'd6,
    REG_FACTORY_LOCK    = 3'd7
  } reg_idx_e;

  // Charger kinds
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_NONSTD = 3'd3;
  localparam logic [2:0] SRC_STD    = 3'd4;

  // Phase override codes: first and last forcing codes
  localparam logic [2:0] OVR_FIRST = 3'd1;
  localparam logic [2:0] OVR_LAST  = 3'd5;

  // Fixed currents and levels
  localparam logic [11:0] CUR_2000_MA = 12'd2000;
  localparam logic [11:0] CUR_400_MA  = 12'd400;
  localparam logic [11:0] CUR_0_MA    = 12'd0;
  localparam logic [6:0]  FULL_LEVEL  = 7'd100;

  // Configuration set
  typedef struct packed {
    logic [12:0] pre_to_cc_mv;
    logic [12:0] recharge_mv;
    logic [11:0] ac_input_ma;
    logic [11:0] nonstd_input_ma;
    logic [11:0] usb_input_ma;
    logic [12:0] cv_target_mv;
    logic [7:0]  tick_seconds;
    logic        factory_lock;
  } cfg_t;

  // One tick request
  typedef struct packed {
    logic [12:0] bat_mv;
    logic [6:0]  charge_level;
    logic        bat_present;
    logic [2:0]  source_kind;
    logic        charger_done;
    logic [2:0]  phase_override;
  } item_t;

  // Controller state
  typedef struct packed {
    phase_e      phase;
    timer_t      pre_seconds;
    timer_t      cc_seconds;
    timer_t      all_seconds;
    logic        full_mark;
    logic        recharge_mark;
    logic        enable_hold;
    logic [11:0] input_limit_hold;
    logic [11:0] charge_current_hold;
  } state_t;

  // One result
  typedef struct packed {
    phase_e                phase;
    logic                  charge_on;
    logic [11:0]           input_limit_ma;
    logic [11:0]           charge_ma;
    logic [12:0]           cv_mv;
    logic                  full_flag;
    logic                  recharging;
    logic                  meter_reset_pulse;
    logic [TOTAL_BITS-1:0] total_seconds;
  } result_t;

  // Saturating timer add
  function automatic timer_t timer_add(timer_t t, logic [7:0] d);
    logic [TIMER_BITS:0] s;
    s = {1'b0, t} + {{(TIMER_BITS-7){1'b0}}, d};
    return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
  endfunction

  // Clamp a timer to the reported total width
  function automatic logic [TOTAL_BITS-1:0] sat_total(timer_t t);
    logic [SAT_BITS-1:0] ext;
    logic [SAT_BITS-1:0] top;
    ext = SAT_BITS'(t);
    top = SAT_BITS'({TOTAL_BITS{1'b1}});
    return (ext > top) ? {TOTAL_BITS{1'b1}} : ext[TOTAL_BITS-1:0];
  endfunction

endpackage

// ===== hdl/bcpc_cfg.sv =====
// Configuration register file with its reset values.
module bcpc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bcpc_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [bcpc_pkg::CFG_DW-1:0] cfg_wdata_i,
  output bcpc_pkg::cfg_t             cfg_o
);

  bcpc_pkg::cfg_t cfg_q, cfg_d;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bcpc_pkg::reg_idx_e'(cfg_idx_i))
        bcpc_pkg::REG_PRE_TO_CC_MV:    cfg_d.pre_to_cc_mv    = cfg_wdata_i[12:0];
        bcpc_pkg::REG_RECHARGE_MV:     cfg_d.recharge_mv     = cfg_wdata_i[12:0];
        bcpc_pkg::REG_AC_INPUT_MA:     cfg_d.ac_input_ma     = cfg_wdata_i[11:0];
        bcpc_pkg::REG_NONSTD_INPUT_MA: cfg_d.nonstd_input_ma = cfg_wdata_i[11:0];
        bcpc_pkg::REG_USB_INPUT_MA:    cfg_d.usb_input_ma    = cfg_wdata_i[11:0];
        bcpc_pkg::REG_CV_TARGET_MV:    cfg_d.cv_target_mv    = cfg_wdata_i[12:0];
        bcpc_pkg::REG_TICK_SECONDS:    cfg_d.tick_seconds    = cfg_wdata_i[7:0];
        bcpc_pkg::REG_FACTORY_LOCK:    cfg_d.factory_lock    = cfg_wdata_i[0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  // Register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_to_cc_mv    <= 13'd3400;
      cfg_q.recharge_mv     <= 13'd4250;
      cfg_q.ac_input_ma     <= 12'd1500;
      cfg_q.nonstd_input_ma <= 12'd500;
      cfg_q.usb_input_ma    <= 12'd500;
      cfg_q.cv_target_mv    <= 13'd4350;
      cfg_q.tick_seconds    <= 8'd10;
      cfg_q.factory_lock    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bcpc_step.sv =====
// Per-tick phase step: next state and result from the current state.
module bcpc_step (
  input  bcpc_pkg::cfg_t    cfg_i,
  input  bcpc_pkg::item_t   item_i,
  input  bcpc_pkg::state_t  state_i,
  output bcpc_pkg::state_t  state_o,
  output bcpc_pkg::result_t result_o
);

  bcpc_pkg::phase_e ph;
  bcpc_pkg::state_t ns;
  logic             pulse;
  logic             run_select;
  logic [11:0]      ilim;
  logic [11:0]      ichg;

  always_comb begin
    ns         = state_i;
    pulse      = 1'b0;
    run_select = 1'b1;
    ilim       = bcpc_pkg::CUR_0_MA;
    ichg       = bcpc_pkg::CUR_0_MA;

    // Forced phase ahead of the step
    ph = state_i.phase;
    if (item_i.phase_override >= bcpc_pkg::OVR_FIRST &&
        item_i.phase_override <= bcpc_pkg::OVR_LAST) begin
      ph = bcpc_pkg::phase_e'(item_i.phase_override - bcpc_pkg::OVR_FIRST);
    end
    ns.phase = ph;

    // Phase action
    unique case (ph)
      bcpc_pkg::PH_PRE: begin
        ns.pre_seconds = bcpc_pkg::timer_add(state_i.pre_seconds, cfg_i.tick_seconds);
        ns.cc_seconds  = '0;
        ns.all_seconds = bcpc_pkg::timer_add(state_i.all_seconds, cfg_i.tick_seconds);
        if (item_i.bat_mv > cfg_i.pre_to_cc_mv) ns.phase = bcpc_pkg::PH_CC;
      end
      bcpc_pkg::PH_CC: begin
        ns.pre_seconds = '0;
        ns.cc_seconds  = bcpc_pkg::timer_add(state_i.cc_seconds, cfg_i.tick_seconds);
        ns.all_seconds = bcpc_pkg::timer_add(state_i.all_seconds, cfg_i.tick_seconds);
        // End of charge
        if (item_i.bat_present && item_i.bat_mv >= cfg_i.recharge_mv &&
            item_i.charger_done) begin
          if (item_i.charge_level >= bcpc_pkg::FULL_LEVEL) ns.phase = bcpc_pkg::PH_FULL;
          ns.full_mark = 1'b1;
          pulse        = 1'b1;
        end
      end
      bcpc_pkg::PH_FULL: begin
        ns.full_mark     = 1'b1;
        ns.all_seconds   = '0;
        ns.pre_seconds   = '0;
        ns.cc_seconds    = '0;
        ns.recharge_mark = 1'b0;
        // Recharge start
        if (item_i.charge_level < bcpc_pkg::FULL_LEVEL ||
            item_i.bat_mv <= cfg_i.recharge_mv) begin
          ns.recharge_mark = 1'b1;
          ns.full_mark     = 1'b0;
          ns.phase         = bcpc_pkg::PH_CC;
        end
      end
      bcpc_pkg::PH_HOLD: begin
        ns.phase = bcpc_pkg::PH_HOLD;
      end
      bcpc_pkg::PH_ERR: begin
        ns.all_seconds = '0;
        ns.pre_seconds = '0;
        ns.cc_seconds  = '0;
        ns.enable_hold = 1'b0;
        run_select     = 1'b0;
      end
      default: begin
        ns.phase   = bcpc_pkg::PH_PRE;
        run_select = 1'b0;
      end
    endcase

    // Current selection by charger kind; the hold phase lowers charge current to 400 mA
    case (item_i.source_kind)
      bcpc_pkg::SRC_NONE: begin
        ilim = bcpc_pkg::CUR_0_MA;
        ichg = bcpc_pkg::CUR_0_MA;
      end
      bcpc_pkg::SRC_NONSTD: begin
        ilim = cfg_i.nonstd_input_ma;
        ichg = bcpc_pkg::CUR_2000_MA;
      end
      bcpc_pkg::SRC_STD: begin
        ilim = cfg_i.ac_input_ma;
        ichg = bcpc_pkg::CUR_2000_MA;
      end
      default: begin
        ilim = cfg_i.usb_input_ma;
        ichg = bcpc_pkg::CUR_2000_MA;
      end
    endcase
    if (ns.phase == bcpc_pkg::PH_HOLD) ichg = bcpc_pkg::CUR_400_MA;

    // Enable decision on the updated phase
    if (run_select) begin
      if (ns.phase == bcpc_pkg::PH_ERR || cfg_i.factory_lock ||
          ns.phase == bcpc_pkg::PH_FULL) begin
        ns.enable_hold = 1'b0;
      end else begin
        ns.input_limit_hold    = ilim;
        ns.charge_current_hold = ichg;
        ns.enable_hold         = (ilim != bcpc_pkg::CUR_0_MA) && (ichg != bcpc_pkg::CUR_0_MA);
      end
    end
  end

  // Result from the updated state
  always_comb begin
    result_o.phase             = ns.phase;
    result_o.charge_on         = ns.enable_hold;
    result_o.input_limit_ma    = ns.input_limit_hold;
    result_o.charge_ma         = ns.charge_current_hold;
    result_o.cv_mv             = ns.enable_hold ? cfg_i.cv_target_mv : 13'd0;
    result_o.full_flag         = ns.full_mark;
    result_o.recharging        = ns.recharge_mark;
    result_o.meter_reset_pulse = pulse;
    result_o.total_seconds     = bcpc_pkg::sat_total(ns.all_seconds);
  end

  assign state_o = ns;

endmodule

// ===== hdl/battery_charge_phase_controller.sv =====
// Top level: input register, phase state, step logic and result register.
// Flow: a request is taken into the input register and stepped when the output
// register is free or being drained; its result is then offered from the output register.
// Throughput: one request per cycle while results are drained; the single state
// update per step is the only loop, and the output register lets a new request in while a result waits.
// Reset: asynchronous, active low; phase returns to precharge, timers and held
// currents clear, and configuration takes its default values.
module battery_charge_phase_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  // Tick requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [12:0] bat_mv_i,
  input  logic [6:0]  charge_level_i,
  input  logic        bat_present_i,
  input  logic [2:0]  source_kind_i,
  input  logic        charger_done_i,
  input  logic [2:0]  phase_override_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  phase_o,
  output logic        charge_on_o,
  output logic [11:0] input_limit_ma_o,
  output logic [11:0] charge_ma_o,
  output logic [12:0] cv_mv_o,
  output logic        full_flag_o,
  output logic        recharging_o,
  output logic        meter_reset_pulse_o,
  output logic [23:0] total_seconds_o
);

  bcpc_pkg::cfg_t    cfg;
  bcpc_pkg::item_t   item_q;
  bcpc_pkg::state_t  state_q, state_d;
  bcpc_pkg::result_t res_q, res_d;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  bcpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcpc_step u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Handshake: step when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.bat_mv         <= bat_mv_i;
      item_q.charge_level   <= charge_level_i;
      item_q.bat_present    <= bat_present_i;
      item_q.source_kind    <= source_kind_i;
      item_q.charger_done   <= charger_done_i;
      item_q.phase_override <= phase_override_i;
    end
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase               <= bcpc_pkg::PH_PRE;
      state_q.pre_seconds         <= '0;
      state_q.cc_seconds          <= '0;
      state_q.all_seconds         <= '0;
      state_q.full_mark           <= 1'b0;
      state_q.recharge_mark       <= 1'b0;
      state_q.enable_hold         <= 1'b0;
      state_q.input_limit_hold    <= '0;
      state_q.charge_current_hold <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o         = out_valid_q;
  assign phase_o             = 3'(res_q.phase);
  assign charge_on_o         = res_q.charge_on;
  assign input_limit_ma_o    = res_q.input_limit_ma;
  assign charge_ma_o         = res_q.charge_ma;
  assign cv_mv_o             = res_q.cv_mv;
  assign full_flag_o         = res_q.full_flag;
  assign recharging_o        = res_q.recharging;
  assign meter_reset_pulse_o = res_q.meter_reset_pulse;
  assign total_seconds_o     = res_q.total_seconds;

`ifndef ASSERT_OFF
  // Charging is never on in full or error
  a_on_not_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && charge_on_o) |->
      (res_q.phase != bcpc_pkg::PH_FULL && res_q.phase != bcpc_pkg::PH_ERR))
    else $error("charge enabled in full or error phase");

  // An enabled charger always has non-zero currents
  a_on_currents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && charge_on_o) |-> (input_limit_ma_o != 12'd0 && charge_ma_o != 12'd0))
    else $error("charge enabled with zero current");

  // Voltage target only goes out with enable
  a_cv_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !charge_on_o) |-> (cv_mv_o == 13'd0))
    else $error("cv target sent while disabled");

  // Gauge reset request comes with the full flag
  a_pulse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && meter_reset_pulse_o) |-> full_flag_o)
    else $error("meter reset without full flag");

  // Error phase stays unless forced into another phase
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.phase == bcpc_pkg::PH_ERR &&
     !(item_q.phase_override >= bcpc_pkg::OVR_FIRST &&
       item_q.phase_override < bcpc_pkg::OVR_LAST))
    |=> (state_q.phase == bcpc_pkg::PH_ERR))
    else $error("error phase left without override");
`endif

endmodule
